// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the array engine RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define IAE_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// An antecedent that must be followed by the consequent in the same cycle.
`define IAE_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/iae_pkg.sv =====
// Types and codes shared by the integer array engine.
// No dependencies; the compare unit and the engine refer to it by scoped names.
package iae_pkg;

    typedef enum logic [2:0] {
        ACT_SET  = 3'd0,
        ACT_GET  = 3'd1,
        ACT_FIND = 3'd2,
        ACT_SORT = 3'd3,
        ACT_PUSH = 3'd4,
        ACT_POP  = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD      = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET_WAIT,
        S_FIND_CMP,
        S_SORT_RDKEY,
        S_SORT_LDKEY,
        S_SORT_CMP,
        S_SORT_PLACE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_res_t;

endpackage

// ===== rtl/iae_if.sv =====
// Request and response channel interfaces of the integer array engine.
// Depends on nothing but the port widths fixed here.
interface iae_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [7:0]         index;
    logic signed [31:0] value;

    modport source (output valid, output action, output index, output value, input ready);
    modport sink   (input valid, input action, input index, input value, output ready);
endinterface

interface iae_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [7:0]         position;
    logic [8:0]         length;

    modport source (output valid, output status, output read_value, output position,
                    output length, input ready);
    modport sink   (input valid, input status, input read_value, input position,
                    input length, output ready);
endinterface

// ===== rtl/iae_mem.sv =====
// Element store of the array engine: one write port and one registered read port.
// Contents are undefined until written; no package dependencies.
module iae_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic signed [31:0] wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic signed [31:0] rd_data
);

    logic signed [31:0] mem_array [DEPTH];
    logic signed [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/iae_cmp.sv =====
// Shared compare unit: equality and signed less-than of two 32-bit words.
// Uses iae_pkg::cmp_res_t for its result.
module iae_cmp (
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output iae_pkg::cmp_res_t  res
);

    always_comb
    begin
        res.eq = (a == b);
        res.lt = (a < b);
    end

endmodule

// ===== rtl/int_array_engine.sv =====
// Integer array engine: a bounded array of signed words with a live length, one
// action per request and one response per request. Set and push go from acceptance
// straight to the done state, as does an out-of-range get or a pop of an empty array;
// other gets and pops first wait for the registered read. Find examines elements up to
// the first match. Sort runs a stable insertion sort through the single read port of
// the element store: for each key it reads the key, loads it, compares it with the
// neighbors below, shifting each larger one up, and then places it.
// The engine takes no new request until the response of the current one has
// moved into the output register; that register holds it while the sink stalls.
// The store needs no clearing after reset; only live elements are ever read.
`include "assert_macros.svh"

module int_array_engine #(
    parameter int CAPACITY = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    iae_req_if.sink   req,
    iae_rsp_if.source rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = (CW > 9) ? CW : 9;
    localparam logic [CW-1:0] CNT_CAP = CW'(CAPACITY);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);
    localparam logic [CW-1:0] CNT_TWO = CW'(2);

    iae_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [CW-1:0]      hole_reg, hole_next;
    logic signed [31:0] op_reg, op_next;
    iae_pkg::status_t   status_reg, status_next;
    logic signed [31:0] rv_reg, rv_next;
    logic [7:0]         pos_reg, pos_next;

    logic               out_valid_reg, out_valid_next;
    iae_pkg::status_t   out_status_reg;
    logic signed [31:0] out_value_reg;
    logic [7:0]         out_pos_reg;
    logic [8:0]         out_len_reg;

    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic signed [31:0] mem_wdata, mem_rdata;
    iae_pkg::cmp_res_t  cmp;

    logic               accept, slot_free, idx_ok, cnt_zero, cnt_full, find_more;
    logic [WW-1:0]      idx_wide, k_wide, count_wide;
    logic [AW-1:0]      idx_addr;
    logic [CW-1:0]      k_plus, k_dec, cnt_dec, hole_dec, hole_dec2;

    iae_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // The operand register holds the search value for find and the key for sort.
    iae_cmp u_cmp (
        .a   (op_reg),
        .b   (mem_rdata),
        .res (cmp)
    );

    assign accept     = req.valid && req.ready;
    assign slot_free  = !out_valid_reg || rsp.ready;
    assign idx_wide   = WW'(req.index);
    assign idx_addr   = idx_wide[AW-1:0];
    assign count_wide = WW'(count_reg);
    assign idx_ok     = idx_wide < count_wide;
    assign cnt_zero   = (count_reg == '0);
    assign cnt_full   = (count_reg >= CNT_CAP);
    assign k_plus     = k_reg + CNT_ONE;
    assign k_dec      = k_reg - CNT_ONE;
    assign k_wide     = WW'(k_reg);
    assign cnt_dec    = count_reg - CNT_ONE;
    assign hole_dec   = hole_reg - CNT_ONE;
    assign hole_dec2  = hole_reg - CNT_TWO;
    assign find_more  = k_plus < count_reg;

    assign req.ready = (state_reg == iae_pkg::S_IDLE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iae_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (iae_pkg::action_t'(req.action))
                        iae_pkg::ACT_GET:
                            state_next = idx_ok ? iae_pkg::S_GET_WAIT : iae_pkg::S_DONE;
                        iae_pkg::ACT_POP:
                            state_next = cnt_zero ? iae_pkg::S_DONE : iae_pkg::S_GET_WAIT;
                        iae_pkg::ACT_FIND:
                            state_next = cnt_zero ? iae_pkg::S_DONE : iae_pkg::S_FIND_CMP;
                        iae_pkg::ACT_SORT:
                            state_next = (count_reg > CNT_ONE) ? iae_pkg::S_SORT_RDKEY
                                                               : iae_pkg::S_DONE;
                        default:
                            state_next = iae_pkg::S_DONE;
                    endcase
                end
            end
            iae_pkg::S_GET_WAIT:
                state_next = iae_pkg::S_DONE;
            iae_pkg::S_FIND_CMP:
            begin
                if (cmp.eq || !find_more)
                begin
                    state_next = iae_pkg::S_DONE;
                end
            end
            iae_pkg::S_SORT_RDKEY:
                state_next = iae_pkg::S_SORT_LDKEY;
            iae_pkg::S_SORT_LDKEY:
                state_next = iae_pkg::S_SORT_CMP;
            iae_pkg::S_SORT_CMP:
            begin
                if (!(cmp.lt && (hole_reg > CNT_ONE)))
                begin
                    state_next = iae_pkg::S_SORT_PLACE;
                end
            end
            iae_pkg::S_SORT_PLACE:
                state_next = (k_plus < count_reg) ? iae_pkg::S_SORT_RDKEY : iae_pkg::S_DONE;
            iae_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = iae_pkg::S_IDLE;
                end
            end
            default:
                state_next = iae_pkg::S_IDLE;
        endcase
    end

    // Memory controls and datapath register updates.
    always_comb
    begin
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        count_next  = count_reg;
        k_next      = k_reg;
        hole_next   = hole_reg;
        op_next     = op_reg;
        status_next = status_reg;
        rv_next     = rv_reg;
        pos_next    = pos_reg;
        case (state_reg)
            iae_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = req.value;
                    status_next = iae_pkg::ST_OK;
                    rv_next     = '0;
                    pos_next    = '0;
                    case (iae_pkg::action_t'(req.action))
                        iae_pkg::ACT_SET:
                        begin
                            if (idx_ok)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = idx_addr;
                                mem_wdata = req.value;
                            end
                            else
                            begin
                                status_next = iae_pkg::ST_BAD;
                            end
                        end
                        iae_pkg::ACT_GET:
                        begin
                            if (idx_ok)
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = idx_addr;
                            end
                            else
                            begin
                                status_next = iae_pkg::ST_BAD;
                            end
                        end
                        iae_pkg::ACT_FIND:
                        begin
                            status_next = iae_pkg::ST_NOTFOUND;
                            k_next      = '0;
                            if (!cnt_zero)
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                            end
                        end
                        iae_pkg::ACT_SORT:
                            k_next = CNT_ONE;
                        iae_pkg::ACT_PUSH:
                        begin
                            if (cnt_full)
                            begin
                                status_next = iae_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = req.value;
                                count_next = count_reg + CNT_ONE;
                            end
                        end
                        iae_pkg::ACT_POP:
                        begin
                            if (cnt_zero)
                            begin
                                status_next = iae_pkg::ST_BAD;
                            end
                            else
                            begin
                                count_next = cnt_dec;
                                mem_re     = 1'b1;
                                mem_raddr  = cnt_dec[AW-1:0];
                            end
                        end
                        default:
                            status_next = iae_pkg::ST_OK;
                    endcase
                end
            end
            iae_pkg::S_GET_WAIT:
                rv_next = mem_rdata;
            iae_pkg::S_FIND_CMP:
            begin
                if (cmp.eq)
                begin
                    status_next = iae_pkg::ST_OK;
                    pos_next    = k_wide[7:0];
                end
                else if (find_more)
                begin
                    k_next    = k_plus;
                    mem_re    = 1'b1;
                    mem_raddr = k_plus[AW-1:0];
                end
            end
            iae_pkg::S_SORT_RDKEY:
            begin
                mem_re    = 1'b1;
                mem_raddr = k_reg[AW-1:0];
            end
            iae_pkg::S_SORT_LDKEY:
            begin
                op_next   = mem_rdata;
                hole_next = k_reg;
                mem_re    = 1'b1;
                mem_raddr = k_dec[AW-1:0];
            end
            iae_pkg::S_SORT_CMP:
            begin
                // Shift the larger neighbor up one place and look one further down.
                if (cmp.lt)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = hole_reg[AW-1:0];
                    mem_wdata = mem_rdata;
                    hole_next = hole_dec;
                    if (hole_reg > CNT_ONE)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = hole_dec2[AW-1:0];
                    end
                end
            end
            iae_pkg::S_SORT_PLACE:
            begin
                mem_we    = 1'b1;
                mem_waddr = hole_reg[AW-1:0];
                mem_wdata = op_reg;
                k_next    = k_plus;
            end
            default:
                k_next = k_reg;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == iae_pkg::S_DONE) && slot_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iae_pkg::S_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            hole_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            hole_reg      <= hole_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        status_reg <= status_next;
        rv_reg     <= rv_next;
        pos_reg    <= pos_next;
        if ((state_reg == iae_pkg::S_DONE) && slot_free)
        begin
            out_status_reg <= status_reg;
            out_value_reg  <= rv_reg;
            out_pos_reg    <= pos_reg;
            out_len_reg    <= count_wide[8:0];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.position   = out_pos_reg;
    assign rsp.length     = out_len_reg;

    `IAE_ASSERT_ALWAYS(a_count_in_range, clk, rst_n, count_reg <= CNT_CAP, "live count above capacity")
    `IAE_ASSERT_IMPLIES(a_hole_live, clk, rst_n, state_reg == iae_pkg::S_SORT_CMP, hole_reg != '0 && hole_reg < count_reg, "sort hole outside live range")
    `IAE_ASSERT_IMPLIES(a_rsp_from_done, clk, rst_n, $rose(out_valid_reg), $past(state_reg == iae_pkg::S_DONE), "response loaded outside done state")
    `IAE_ASSERT_IMPLIES(a_count_on_request, clk, rst_n, count_reg != $past(count_reg), $past(req.valid && req.ready), "live count changed without a request")

endmodule
